@@ rtl/core/tdpt_pkg.sv @@
// Shared types for the trial division prime test block.
package tdpt_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT
  } tdpt_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tdpt_div_stat_t;

endpackage

@@ rtl/core/tdpt_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module tdpt_div
  import tdpt_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  div_start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output tdpt_div_stat_t        div_stat,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic [DATA_WIDTH-1:0] remainder
);

  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] dsr_r, dsr_nxt;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;

  // Shift in the next dividend bit and try the subtraction.
  assign trial = {rem_r, quo_r[DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (div_start) begin
      cnt_nxt = CW'(DATA_WIDTH);
      rem_nxt = '0;
      quo_nxt = dividend;
      dsr_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CW'(1);
      if (!diff[DATA_WIDTH]) begin
        rem_nxt = diff[DATA_WIDTH-1:0];
        quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DATA_WIDTH-1:0];
        quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b0};
      end
      if (cnt_r == CW'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign div_stat.busy = (cnt_r != '0);
  assign div_stat.done = done_r;
  assign quotient      = quo_r;
  assign remainder     = rem_r;

endmodule

@@ rtl/core/trial_division_prime_test.sv @@
// Top level of the trial division prime test: sequencer around a shared divider.
//
// Usage: drive in_number and pulse start while busy is low; that edge takes
// the request. The block answers with exactly one result, shown for a single
// cycle with out_valid high: out_prime and out_largest_divisor (the
// largest proper divisor, zero when prime or when the number is 0 or 1).
// The receiver cannot stall: it must capture the result in that cycle.
//
// Flow: numbers below 4 and even numbers answer in the cycle after start is
// taken and leave busy low, so such requests may follow back to back. Odd
// numbers of 5 and up try odd candidates 3, 5, 7 and so on through one shared
// restoring divider; each candidate is launched from ST_LAUNCH, divided bit
// by bit, and judged in ST_WAIT. The search stops at the first candidate
// that divides, or once the candidate exceeds the quotient; a 32-bit prime
// near 2^32 thus needs about 32768 candidates. busy is high for the whole
// search and drops as out_valid rises.
//
// Reset: synchronous, active low; returns the sequencer to idle and drops
// busy and out_valid. out_prime and out_largest_divisor keep the last result.
module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [DATA_WIDTH-1:0] in_number,
  output logic                  out_valid,
  output logic                  out_prime,
  output logic [31:0]           out_largest_divisor
);

  tdpt_state_t           state_r, state_nxt;
  logic [DATA_WIDTH-1:0] num_r, num_nxt;
  logic [DATA_WIDTH-1:0] cand_r, cand_nxt;
  logic                  valid_r, valid_nxt;
  logic                  prime_r, prime_nxt;
  logic [31:0]           ldiv_r, ldiv_nxt;
  logic                  div_start;
  tdpt_div_stat_t        div_stat;
  logic [DATA_WIDTH-1:0] div_quo;
  logic [DATA_WIDTH-1:0] div_rem;
  logic [63:0]           half_ext;
  logic [63:0]           quo_ext;

  // Zero-extend to 64 bits; only the low 32 bits reach the divisor field.
  assign half_ext = 64'(in_number >> 1);
  assign quo_ext  = 64'(div_quo);

  tdpt_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .div_start(div_start),
    .dividend (num_r),
    .divisor  (cand_r),
    .div_stat (div_stat),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    cand_nxt  = cand_r;
    valid_nxt = 1'b0;
    prime_nxt = prime_r;
    ldiv_nxt  = ldiv_r;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          num_nxt = in_number;
          if (in_number < DATA_WIDTH'(2)) begin
            // zero and one: not prime
            valid_nxt = 1'b1;
            prime_nxt = 1'b0;
            ldiv_nxt  = '0;
          end else if (in_number < DATA_WIDTH'(4)) begin
            valid_nxt = 1'b1;
            prime_nxt = 1'b1;
            ldiv_nxt  = '0;
          end else if (!in_number[0]) begin
            // even: smallest factor is two
            valid_nxt = 1'b1;
            prime_nxt = 1'b0;
            ldiv_nxt  = half_ext[31:0];
          end else begin
            cand_nxt  = DATA_WIDTH'(3);
            state_nxt = ST_LAUNCH;
          end
        end
      end
      ST_LAUNCH: begin
        div_start = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_stat.done) begin
          if (div_quo < cand_r) begin
            // candidate passed the square root: no factor left
            valid_nxt = 1'b1;
            prime_nxt = 1'b1;
            ldiv_nxt  = '0;
            state_nxt = ST_IDLE;
          end else if (div_rem == '0) begin
            valid_nxt = 1'b1;
            prime_nxt = 1'b0;
            ldiv_nxt  = quo_ext[31:0];
            state_nxt = ST_IDLE;
          end else begin
            // advance to the next odd candidate
            cand_nxt  = cand_r + DATA_WIDTH'(2);
            state_nxt = ST_LAUNCH;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    num_r   <= num_nxt;
    cand_r  <= cand_nxt;
    prime_r <= prime_nxt;
    ldiv_r  <= ldiv_nxt;
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = valid_r;
  assign out_prime           = prime_r;
  assign out_largest_divisor = ldiv_r;

  // An accepted request either finishes at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted request neither answered nor in progress");

  // A prime result never carries a divisor.
  a_prime_no_div: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_prime) |-> (out_largest_divisor == '0))
    else $error("prime result with nonzero divisor");

  // Divider results arrive only while the sequencer waits for them.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_WAIT))
    else $error("divider finished outside wait state");

  // Candidates under test are odd and at least three.
  a_cand_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT) |-> (cand_r[0] && (cand_r >= DATA_WIDTH'(3))))
    else $error("bad trial candidate");

  // The divider is launched only when idle.
  a_launch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider launched while busy");

endmodule
